// ===== rtl/bls_pkg.sv =====
// Shared types, codes and defaults for the bounded LIFO stack unit.
`default_nettype none

package bls_pkg;

    // Default number of memory entries behind the stack.
    localparam int BLS_DEPTH = 64;

    // Width of the capacity register and of the count field.
    localparam int CAP_W = 7;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Request kinds.
    localparam logic [2:0] MODE_PUSH  = 3'd0;
    localparam logic [2:0] MODE_POP   = 3'd1;
    localparam logic [2:0] MODE_PEEK  = 3'd2;
    localparam logic [2:0] MODE_SHOW  = 3'd3;
    localparam logic [2:0] MODE_CLEAR = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] push_value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] data;
        logic               data_valid;
        logic [1:0]         status;
        logic [CAP_W-1:0]   count;
        logic               is_empty;
        logic               is_full;
        logic               last;
    } t_rsp;

endpackage

`default_nettype wire

// ===== rtl/bounded_lifo_stack_unit.sv =====
// Top level of the bounded LIFO stack unit: request sequencer and entry memory.
//
// Usage: requests arrive on the input channel (i_in_valid, o_in_stall, i_in) and
// results leave on the output channel (o_out_valid, i_out_stall, o_out). A word
// moves on a channel at a rising clock edge where valid is high and stall is low.
// Each request is a push, pop, peek, show or clear; each result word carries the
// entry value (if any), a status, the count after the request and the empty and
// full flags, and last marks the final word of a request.
// Push, clear and unused modes give their word in the cycle after acceptance,
// and a new request can follow once the output register is free. Pop and peek
// read the entry memory first, so their word passes the memory read register and
// then the output register. Show streams one word per cycle while the receiver
// does not stall, top entry first. Only one request is in work at a time. The
// capacity register is written through i_cfg_we / i_cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
// Reset empties the stack and sets the capacity to 64; memory contents stay as
// they were and are never read before a push writes them.
// When the receiver stalls, the output word holds and the block stops taking
// requests and stops a show stream until the output register is free again.
`default_nettype none

module bounded_lifo_stack_unit
    import bls_pkg::*;
#(
    parameter int DEPTH = BLS_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_req             i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_rsp                  o_out
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CAP_W-1:0] DEPTH_C = CAP_W'(DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DATA = 1'b1;

    // Builds a result word; the flags follow from the count after the request.
    function automatic t_rsp make_rsp(
        input logic [31:0]      data,
        input logic             dvalid,
        input logic [1:0]       status,
        input logic [CAP_W-1:0] cnt,
        input logic [CAP_W-1:0] cap,
        input logic             last
    );
        t_rsp r;
        r.data       = data;
        r.data_valid = dvalid;
        r.status     = status;
        r.count      = cnt;
        r.is_empty   = (cnt == '0);
        r.is_full    = (cnt >= cap);
        r.last       = last;
        return r;
    endfunction

    logic             r_state, n_state;
    logic             r_show, n_show;
    logic [AW-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CAP_W-1:0] r_cap;
    logic             r_out_valid, n_out_valid;
    t_rsp             r_out, n_out;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [31:0]      ram_rdata;

    logic             out_free, in_acc, full, empty;
    logic [CAP_W-1:0] cnt7, eff_cap;
    logic [CNT_W-1:0] cnt_m1;
    logic [AW-1:0]    top_addr, idx_m1;

    bls_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_in.push_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // A capacity above the memory depth behaves as the memory depth.
    assign eff_cap  = (r_cap > DEPTH_C) ? DEPTH_C : r_cap;
    assign cnt7     = CAP_W'(r_cnt);
    assign full     = (cnt7 >= eff_cap);
    assign empty    = (r_cnt == '0);
    assign cnt_m1   = r_cnt - CNT_W'(1);
    assign top_addr = cnt_m1[AW-1:0];
    assign idx_m1   = r_idx - AW'(1);

    // The output register is free when empty or when its word leaves this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_acc     = i_in_valid && (r_state == S_IDLE) && out_free;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);

    always_comb begin
        n_state     = r_state;
        n_show      = r_show;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = top_addr;

        if (r_state == S_IDLE) begin
            if (in_acc) begin
                case (i_in.mode)
                    MODE_PUSH: begin
                        n_out_valid = 1'b1;
                        if (full) begin
                            n_out = make_rsp('0, 1'b0, ST_OVF, cnt7, eff_cap, 1'b1);
                        end else begin
                            ram_we = 1'b1;
                            n_cnt  = r_cnt + CNT_W'(1);
                            n_out  = make_rsp('0, 1'b0, ST_OK, CAP_W'(n_cnt), eff_cap,
                                              1'b1);
                        end
                    end
                    MODE_POP, MODE_PEEK, MODE_SHOW: begin
                        if (empty) begin
                            n_out_valid = 1'b1;
                            n_out = make_rsp('0, 1'b0, ST_EMPTY, cnt7, eff_cap, 1'b1);
                        end else begin
                            // Read the top entry; the word is formed when it returns.
                            ram_re  = 1'b1;
                            n_idx   = top_addr;
                            n_show  = (i_in.mode == MODE_SHOW);
                            n_state = S_DATA;
                            if (i_in.mode == MODE_POP) begin
                                n_cnt = cnt_m1;
                            end
                        end
                    end
                    MODE_CLEAR: begin
                        n_cnt       = '0;
                        n_out_valid = 1'b1;
                        n_out = make_rsp('0, 1'b0, ST_OK, '0, eff_cap, 1'b1);
                    end
                    default: begin
                        n_out_valid = 1'b1;
                        n_out = make_rsp('0, 1'b0, ST_OK, cnt7, eff_cap, 1'b1);
                    end
                endcase
            end
        end else begin
            // Read data holds while no new read is issued, so a stall just waits.
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out = make_rsp(ram_rdata, 1'b1, ST_OK, cnt7, eff_cap,
                                 !r_show || (r_idx == '0));
                if (r_show && (r_idx != '0)) begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_m1;
                    n_idx     = idx_m1;
                end else begin
                    n_state = S_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_show <= n_show;
        r_idx  <= n_idx;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The count never goes past the memory depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("entry count above memory depth");

    // Memory writes happen only while no read sequence is in work.
    a_we_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE))
        else $error("memory write during a read sequence");

    // An accepted request gives a word or starts a read at the next edge.
    a_acc_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_out_valid || (r_state == S_DATA)))
        else $error("accepted request produced nothing");

    // During a show stream the read pointer stays below the count.
    a_show_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DATA) && r_show) |-> (CNT_W'(r_idx) < r_cnt))
        else $error("show pointer outside held entries");

    // A word carrying an entry value always has ok status.
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.data_valid) |-> (r_out.status == ST_OK))
        else $error("entry value with error status");

endmodule

`default_nettype wire

// ===== rtl/bls_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module bls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // The read data holds its value until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
